>>> hdl/smc_pkg.sv
package smc_pkg;

    localparam int TABLE_LEN_DEF    = 64;
    localparam int PHASE_OFFSET_DEF = 16;

    localparam int ROM_LEN    = 64;
    localparam int ROM_IDX_W  = 6;
    localparam int DIV_STEPS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    localparam logic [12:0] FOREVER_COUNT = 13'h1fff;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CONSTANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFORT_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_CODE    = 3'd4;

    localparam logic [15:0] RATE_CONSTANT_RST = 16'd18750;
    localparam logic [15:0] MIN_INTERVAL_RST  = 16'd100;
    localparam logic [6:0]  EFFORT_MAX_RST    = 7'd115;
    localparam logic [1:0]  STEP_CODE_RST     = 2'd1;
    localparam logic [1:0]  SETUP_CODE_RST    = 2'd2;
    localparam logic [6:0]  EFFORT_RST        = 7'd37;
    localparam logic [15:0] INTERVAL_RST      = 16'd100;

    localparam logic signed [7:0] SINE_ROM [ROM_LEN] = '{
        8'sd0, 8'sd12, 8'sd25, 8'sd37, 8'sd49, 8'sd60, 8'sd71, 8'sd81,
        8'sd90, 8'sd98, 8'sd106, 8'sd112, 8'sd117, 8'sd122, 8'sd125, 8'sd126,
        8'sd127, 8'sd126, 8'sd125, 8'sd122, 8'sd117, 8'sd112, 8'sd106, 8'sd98,
        8'sd90, 8'sd81, 8'sd71, 8'sd60, 8'sd49, 8'sd37, 8'sd25, 8'sd12,
        8'sd0, -8'sd12, -8'sd25, -8'sd37, -8'sd49, -8'sd60, -8'sd71, -8'sd81,
        -8'sd90, -8'sd98, -8'sd106, -8'sd112, -8'sd117, -8'sd122, -8'sd125, -8'sd126,
        -8'sd127, -8'sd126, -8'sd125, -8'sd122, -8'sd117, -8'sd112, -8'sd106, -8'sd98,
        -8'sd90, -8'sd81, -8'sd71, -8'sd60, -8'sd49, -8'sd37, -8'sd25, -8'sd12
    };

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIVIDE
    } smc_state_t;

    typedef struct packed {
        logic apply;
        logic div_start;
        logic commit;
    } smc_cmd_t;

    typedef struct packed {
        logic is_step;
        logic div_done;
    } smc_status_t;

endpackage

>>> hdl/smc_if.sv
interface smc_item_if;
    import smc_pkg::*;

    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;

    modport source (output valid, kind, byte0, byte1, byte2, byte3, input ready);
    modport sink (input valid, kind, byte0, byte1, byte2, byte3, output ready);
endinterface

interface smc_result_if;
    import smc_pkg::*;

    logic       valid;
    logic       ready;
    logic [6:0] pwm_a;
    logic [6:0] pwm_b;
    logic [3:0] bridge;
    logic       running;
    logic       frame_ok;

    modport source (output valid, pwm_a, pwm_b, bridge, running, frame_ok, input ready);
    modport sink (input valid, pwm_a, pwm_b, bridge, running, frame_ok, output ready);
endinterface

interface smc_cfg_if;
    import smc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/smc_div.sv
module smc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic [15:0] quotient,
    output logic        done
);
    import smc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      quot_reg, quot_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       dsor_reg, dsor_next;
    logic [8:0]       trial;
    logic             fits;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dsor_next  = dsor_reg;
        trial      = {rem_reg, quot_reg[15]};
        fits       = (trial >= {1'b0, dsor_reg});
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quot_next  = dividend;
            rem_next   = '0;
            dsor_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? 8'(trial - {1'b0, dsor_reg}) : trial[7:0];
            quot_next  = {quot_reg[14:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

>>> hdl/smc_datapath.sv
module smc_datapath #(
    parameter int TABLE_LEN    = smc_pkg::TABLE_LEN_DEF,
    parameter int PHASE_OFFSET = smc_pkg::PHASE_OFFSET_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  smc_pkg::smc_cmd_t               cmd,
    output smc_pkg::smc_status_t            status,
    input  logic                            item_kind,
    input  logic [7:0]                      item_byte0,
    input  logic [7:0]                      item_byte1,
    input  logic [7:0]                      item_byte2,
    input  logic [7:0]                      item_byte3,
    input  logic                            cfg_write,
    input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [6:0]                      pwm_a,
    output logic [6:0]                      pwm_b,
    output logic [3:0]                      bridge,
    output logic                            running,
    output logic                            frame_ok
);
    import smc_pkg::*;

    localparam int PHASE_W = $clog2(TABLE_LEN);
    localparam logic [PHASE_W-1:0] LAST_PHASE  = PHASE_W'(TABLE_LEN - 1);
    localparam logic [PHASE_W-1:0] PHASE_B_RST = PHASE_W'(PHASE_OFFSET % TABLE_LEN);

    // resample phase onto the ROM: multiply by a rounded-up reciprocal of the table length
    localparam int SCALE_W     = PHASE_W + ROM_IDX_W;
    localparam int RECIP_SHIFT = SCALE_W + PHASE_W;
    localparam int RECIP_W     = SCALE_W + 1;
    localparam int PROD_W      = SCALE_W + RECIP_W;
    localparam longint RECIP_VAL = ((longint'(1) << RECIP_SHIFT) + longint'(TABLE_LEN)
                                   - longint'(1)) / longint'(TABLE_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    typedef struct packed {
        logic [6:0] mag;
        logic       nonneg;
    } coil_t;

    function automatic coil_t coil_drive(input logic signed [7:0] s, input logic [6:0] eff);
        logic [6:0]  a;
        logic [13:0] prod;
        coil_t       c;
        a        = s[7] ? 7'(-s) : s[6:0];
        prod     = 14'(a) * 14'(eff);
        c.mag    = prod[13:7];
        c.nonneg = !s[7] || (prod[13:7] == 7'd0);
        return c;
    endfunction

    function automatic logic [PHASE_W-1:0] advance(input logic [PHASE_W-1:0] p,
                                                   input logic fwd);
        logic [PHASE_W-1:0] r;
        if (fwd)
            r = (p == LAST_PHASE) ? '0 : p + 1'b1;
        else
            r = (p == '0) ? LAST_PHASE : p - 1'b1;
        return r;
    endfunction

    logic [15:0] rate_constant_reg;
    logic [15:0] min_interval_reg;
    logic [6:0]  effort_max_reg;
    logic [1:0]  step_code_reg;
    logic [1:0]  setup_code_reg;

    logic [PHASE_W-1:0] phase_a_reg, phase_a_next;
    logic [PHASE_W-1:0] phase_b_reg, phase_b_next;
    logic [12:0]        steps_left_reg, steps_left_next;
    logic               direction_reg, direction_next;
    logic [6:0]         effort_reg, effort_next;
    logic [15:0]        interval_reg, interval_next;
    logic [15:0]        tick_count_reg, tick_count_next;
    logic [6:0]         drive_a_reg, drive_a_next;
    logic [6:0]         drive_b_reg, drive_b_next;
    logic [3:0]         bridge_reg, bridge_next;
    logic               running_reg, running_next;
    logic [12:0]        pend_steps_reg, pend_steps_next;
    logic               pend_dir_reg, pend_dir_next;

    logic [6:0] res_pwm_a_reg, res_pwm_b_reg;
    logic [3:0] res_bridge_reg;
    logic       res_running_reg, res_frame_ok_reg;
    logic       ok_next;

    logic                  sum_ok;
    logic                  frame_good;
    logic [1:0]            cmd_code;
    logic [SCALE_W-1:0]    scaled_a, scaled_b;
    logic [PROD_W-1:0]     recip_a, recip_b;
    logic [ROM_IDX_W-1:0]  idx_a, idx_b;
    coil_t                 coil_a, coil_b;
    logic [15:0]           tick_inc;
    logic [15:0]           quotient;
    logic                  div_done;
    logic [7:0]            divisor;

    assign sum_ok     = (8'(item_byte0 + item_byte1 + item_byte2) == item_byte3);
    assign frame_good = (item_kind == KIND_FRAME) && sum_ok;
    assign cmd_code   = item_byte0[7:6];
    assign divisor    = (item_byte2 == 8'd0) ? 8'd1 : item_byte2;

    assign status.is_step  = frame_good && (cmd_code == step_code_reg);
    assign status.div_done = div_done;

    smc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rate_constant_reg),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign scaled_a = {phase_a_reg, {ROM_IDX_W{1'b0}}};
    assign scaled_b = {phase_b_reg, {ROM_IDX_W{1'b0}}};
    assign recip_a  = PROD_W'(scaled_a) * PROD_W'(RECIP);
    assign recip_b  = PROD_W'(scaled_b) * PROD_W'(RECIP);
    assign idx_a    = recip_a[RECIP_SHIFT +: ROM_IDX_W];
    assign idx_b    = recip_b[RECIP_SHIFT +: ROM_IDX_W];
    assign coil_a   = coil_drive(SINE_ROM[idx_a], effort_reg);
    assign coil_b   = coil_drive(SINE_ROM[idx_b], effort_reg);
    assign tick_inc = tick_count_reg + 16'd1;

    always_comb
    begin
        phase_a_next    = phase_a_reg;
        phase_b_next    = phase_b_reg;
        steps_left_next = steps_left_reg;
        direction_next  = direction_reg;
        effort_next     = effort_reg;
        interval_next   = interval_reg;
        tick_count_next = tick_count_reg;
        drive_a_next    = drive_a_reg;
        drive_b_next    = drive_b_reg;
        bridge_next     = bridge_reg;
        running_next    = running_reg;
        pend_steps_next = pend_steps_reg;
        pend_dir_next   = pend_dir_reg;
        ok_next         = 1'b0;

        if (cmd.div_start)
        begin
            pend_steps_next = {item_byte0[4:0], item_byte1};
            pend_dir_next   = item_byte0[5];
        end

        if (cmd.apply)
        begin
            ok_next = frame_good;
            if (item_kind == KIND_TICK)
            begin
                if (running_reg)
                begin
                    if (tick_inc >= interval_reg)
                    begin
                        tick_count_next = '0;
                        if (steps_left_reg != 13'd0)
                        begin
                            drive_a_next = coil_a.mag;
                            drive_b_next = coil_b.mag;
                            bridge_next  = {coil_b.nonneg, !coil_b.nonneg,
                                            coil_a.nonneg, !coil_a.nonneg};
                            phase_a_next = advance(phase_a_reg, direction_reg);
                            phase_b_next = advance(phase_b_reg, direction_reg);
                            if (steps_left_reg != FOREVER_COUNT)
                                steps_left_next = steps_left_reg - 13'd1;
                        end
                        else
                        begin
                            running_next = 1'b0;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_inc;
                    end
                end
            end
            else if (frame_good && (cmd_code == setup_code_reg))
            begin
                effort_next = (item_byte1 > {1'b0, effort_max_reg}) ?
                              effort_max_reg : item_byte1[6:0];
            end
        end

        if (cmd.commit)
        begin
            ok_next         = 1'b1;
            steps_left_next = pend_steps_reg;
            direction_next  = pend_dir_reg;
            interval_next   = (quotient < min_interval_reg) ? min_interval_reg : quotient;
            tick_count_next = '0;
            running_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_constant_reg <= RATE_CONSTANT_RST;
            min_interval_reg  <= MIN_INTERVAL_RST;
            effort_max_reg    <= EFFORT_MAX_RST;
            step_code_reg     <= STEP_CODE_RST;
            setup_code_reg    <= SETUP_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RATE_CONSTANT: rate_constant_reg <= cfg_data[15:0];
                CFG_MIN_INTERVAL:  min_interval_reg  <= cfg_data[15:0];
                CFG_EFFORT_MAX:    effort_max_reg    <= cfg_data[6:0];
                CFG_STEP_CODE:     step_code_reg     <= cfg_data[1:0];
                CFG_SETUP_CODE:    setup_code_reg    <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_a_reg    <= '0;
            phase_b_reg    <= PHASE_B_RST;
            steps_left_reg <= '0;
            direction_reg  <= 1'b0;
            effort_reg     <= EFFORT_RST;
            interval_reg   <= INTERVAL_RST;
            tick_count_reg <= '0;
            drive_a_reg    <= '0;
            drive_b_reg    <= '0;
            bridge_reg     <= '0;
            running_reg    <= 1'b0;
        end
        else
        begin
            phase_a_reg    <= phase_a_next;
            phase_b_reg    <= phase_b_next;
            steps_left_reg <= steps_left_next;
            direction_reg  <= direction_next;
            effort_reg     <= effort_next;
            interval_reg   <= interval_next;
            tick_count_reg <= tick_count_next;
            drive_a_reg    <= drive_a_next;
            drive_b_reg    <= drive_b_next;
            bridge_reg     <= bridge_next;
            running_reg    <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_steps_reg <= pend_steps_next;
        pend_dir_reg   <= pend_dir_next;
        if (cmd.apply || cmd.commit)
        begin
            res_pwm_a_reg    <= drive_a_next;
            res_pwm_b_reg    <= drive_b_next;
            res_bridge_reg   <= bridge_next;
            res_running_reg  <= running_next;
            res_frame_ok_reg <= ok_next;
        end
    end

    assign pwm_a    = res_pwm_a_reg;
    assign pwm_b    = res_pwm_b_reg;
    assign bridge   = res_bridge_reg;
    assign running  = res_running_reg;
    assign frame_ok = res_frame_ok_reg;

endmodule

>>> hdl/smc_ctrl.sv
module smc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  smc_pkg::smc_status_t status,
    output smc_pkg::smc_cmd_t    cmd
);
    import smc_pkg::*;

    smc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;
    logic       out_load;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free)
                begin
                    if (status.is_step)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                    else
                    begin
                        cmd.apply = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_load       = cmd.apply || cmd.commit;
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result loaded over an untaken request");

    a_done_only_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside a step command");

    a_start_enters_divide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_DIVIDE) && !out_valid_reg)
        else $error("step command did not hold for the divider");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("step command result not presented");

endmodule

>>> hdl/stepper_microstep_command_controller_top.sv
// Sine microstepping controller for a two-phase stepper. Each request is a
// one-microsecond tick or a checked four-byte command frame, and each gives
// one result with the coil PWM magnitudes, bridge polarity, run flag and
// frame status. A tick or non-step frame presents its result on the edge
// that accepts it, so the result can be taken in the following cycle; a
// step frame presents its result once the 16-step shift-subtract divider
// that turns the speed byte into the step interval has finished and the
// interval has been committed. A new request is taken while the previous
// result waits, as long as that result is taken in the same cycle.
// Configuration writes are always accepted and should be issued only while
// no request is outstanding.
module stepper_microstep_command_controller_top #(
    parameter int TABLE_LEN    = smc_pkg::TABLE_LEN_DEF,
    parameter int PHASE_OFFSET = smc_pkg::PHASE_OFFSET_DEF
) (
    input logic          clk,
    input logic          rst_n,
    smc_item_if.sink     item,
    smc_result_if.source result,
    smc_cfg_if.sink      cfg
);
    import smc_pkg::*;

    smc_cmd_t    cmd;
    smc_status_t status;

    assign cfg.ready = 1'b1;

    smc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    smc_datapath #(
        .TABLE_LEN    (TABLE_LEN),
        .PHASE_OFFSET (PHASE_OFFSET)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .item_kind  (item.kind),
        .item_byte0 (item.byte0),
        .item_byte1 (item.byte1),
        .item_byte2 (item.byte2),
        .item_byte3 (item.byte3),
        .cfg_write  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .pwm_a      (result.pwm_a),
        .pwm_b      (result.pwm_b),
        .bridge     (result.bridge),
        .running    (result.running),
        .frame_ok   (result.frame_ok)
    );

endmodule

>>> dv/smc_checker.sv
`timescale 1ns / 100ps

module smc_checker (
    input  logic   clk,
    input  logic   rst_n,
    smc_item_if    item,
    smc_result_if  result,
    smc_cfg_if     cfg,
    output int     mismatches,
    output int     outstanding
);
    import smc_pkg::*;

    typedef struct packed {
        logic [6:0] pwm_a;
        logic [6:0] pwm_b;
        logic [3:0] bridge;
        logic       running;
        logic       frame_ok;
    } drive_word_t;

    drive_word_t drive_expected[$];
    drive_word_t want;
    drive_word_t got;

    logic [15:0] rate_num;
    logic [15:0] floor_iv;
    logic [6:0]  effort_cap;
    logic [1:0]  step_cmd;
    logic [1:0]  setup_cmd;

    logic [5:0]  ph_a;
    logic [5:0]  ph_b;
    logic [12:0] steps_to_go;
    logic        fwd;
    logic [6:0]  effort_lvl;
    logic [15:0] step_iv;
    logic [15:0] us_count;
    logic [6:0]  coil_a;
    logic [6:0]  coil_b;
    logic [3:0]  bridge_bits;
    logic        timer_on;

    function automatic void coil_level(input logic signed [7:0] s, output logic [6:0] mag,
                                       output logic nonneg);
        logic [7:0]  a;
        logic [14:0] prod;
        a = (s < 0) ? 8'(-s) : 8'(s);
        prod = 15'(a) * 15'(effort_lvl);
        mag = prod[13:7];
        nonneg = (s >= 0) || (mag == 7'd0);
    endfunction

    function automatic drive_word_t predict_drive(input logic k, input logic [7:0] b0,
                                                  input logic [7:0] b1, input logic [7:0] b2,
                                                  input logic [7:0] b3);
        drive_word_t w;
        logic        pa;
        logic        pb;
        logic        ok;
        logic [7:0]  sum;
        logic [7:0]  speed;
        logic [15:0] iv;
        ok = 1'b0;
        if (k == KIND_TICK) begin
            if (timer_on) begin
                us_count = us_count + 16'd1;
                if (us_count >= step_iv) begin
                    us_count = 16'd0;
                    if (steps_to_go != 13'd0) begin
                        coil_level(SINE_ROM[ph_a], coil_a, pa);
                        coil_level(SINE_ROM[ph_b], coil_b, pb);
                        bridge_bits = {pb, ~pb, pa, ~pa};
                        ph_a = fwd ? ph_a + 6'd1 : ph_a - 6'd1;
                        ph_b = fwd ? ph_b + 6'd1 : ph_b - 6'd1;
                        if (steps_to_go != FOREVER_COUNT)
                            steps_to_go = steps_to_go - 13'd1;
                    end
                    else
                    begin
                        timer_on = 1'b0;
                    end
                end
            end
        end
        else
        begin
            sum = b0 + b1 + b2;
            if (sum == b3) begin
                ok = 1'b1;
                if (b0[7:6] == step_cmd) begin
                    speed = (b2 == 8'd0) ? 8'd1 : b2;
                    iv = rate_num / 16'(speed);
                    if (iv < floor_iv)
                        iv = floor_iv;
                    steps_to_go = {b0[4:0], b1};
                    fwd = b0[5];
                    step_iv = iv;
                    us_count = 16'd0;
                    timer_on = 1'b1;
                end
                else if (b0[7:6] == setup_cmd) begin
                    effort_lvl = (b1 > {1'b0, effort_cap}) ? effort_cap : b1[6:0];
                end
            end
        end
        w.pwm_a = coil_a;
        w.pwm_b = coil_b;
        w.bridge = bridge_bits;
        w.running = timer_on;
        w.frame_ok = ok;
        return w;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            rate_num = RATE_CONSTANT_RST;
            floor_iv = MIN_INTERVAL_RST;
            effort_cap = EFFORT_MAX_RST;
            step_cmd = STEP_CODE_RST;
            setup_cmd = SETUP_CODE_RST;
            ph_a = 6'd0;
            ph_b = 6'(PHASE_OFFSET_DEF % TABLE_LEN_DEF);
            steps_to_go = 13'd0;
            fwd = 1'b0;
            effort_lvl = EFFORT_RST;
            step_iv = INTERVAL_RST;
            us_count = 16'd0;
            coil_a = 7'd0;
            coil_b = 7'd0;
            bridge_bits = 4'd0;
            timer_on = 1'b0;
            drive_expected.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_RATE_CONSTANT: rate_num = cfg.data;
                    CFG_MIN_INTERVAL:  floor_iv = cfg.data;
                    CFG_EFFORT_MAX:    effort_cap = cfg.data[6:0];
                    CFG_STEP_CODE:     step_cmd = cfg.data[1:0];
                    CFG_SETUP_CODE:    setup_cmd = cfg.data[1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready) begin
                got = '{result.pwm_a, result.pwm_b, result.bridge, result.running,
                        result.frame_ok};
                if (drive_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected result a=%0d b=%0d br=%h run=%b ok=%b",
                                 $time, got.pwm_a, got.pwm_b, got.bridge, got.running,
                                 got.frame_ok);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (got.pwm_a !== want.pwm_a || got.pwm_b !== want.pwm_b ||
                        got.bridge !== want.bridge || got.running !== want.running ||
                        got.frame_ok !== want.frame_ok) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t mismatch exp a=%0d b=%0d br=%h run=%b ok=%b %s",
                                     $time, want.pwm_a, want.pwm_b, want.bridge,
                                     want.running, want.frame_ok, "got:");
                        if (mismatches <= 10)
                            $display("    got a=%0d b=%0d br=%h run=%b ok=%b",
                                     got.pwm_a, got.pwm_b, got.bridge, got.running,
                                     got.frame_ok);
                    end
                end
            end
            if (item.valid && item.ready)
                drive_expected.push_back(predict_drive(item.kind, item.byte0, item.byte1,
                                                       item.byte2, item.byte3));
        end
        outstanding = drive_expected.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import smc_pkg::*;

    localparam logic [1:0] CMD_SPARE_LO = 2'd0;
    localparam logic [1:0] CMD_SPARE_HI = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_ITEMS = 270;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   hold_asked;
    int   hold_served;
    bit   src_idle;
    bit   sink_idle;
    logic [1:0] step_cmd;
    logic [1:0] setup_cmd;

    smc_item_if   item_bus ();
    smc_result_if result_bus ();
    smc_cfg_if    cfg_bus ();

    stepper_microstep_command_controller_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    smc_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_bus),
        .result      (result_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        result_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_asked) begin
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_served++;
            end
            else
            begin
                result_bus.ready <= !(sink_idle && $urandom_range(99) < 25);
            end
        end
    end

    task automatic offer_request(input logic k, input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [7:0] b3);
        while (src_idle && $urandom_range(99) < 25) begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.kind <= k;
        item_bus.byte0 <= b0;
        item_bus.byte1 <= b1;
        item_bus.byte2 <= b2;
        item_bus.byte3 <= b3;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
    endtask

    task automatic send_tick();
        offer_request(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input bit good);
        logic [7:0] sum;
        sum = b0 + b1 + b2;
        if (!good)
            sum = sum + 8'($urandom_range(1, 255));
        offer_request(KIND_FRAME, b0, b1, b2, sum);
    endtask

    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] rate, input logic [15:0] floor_us,
                                 input logic [6:0] cap, input logic [1:0] sc,
                                 input logic [1:0] uc);
        write_reg(CFG_RATE_CONSTANT, rate);
        write_reg(CFG_MIN_INTERVAL, floor_us);
        write_reg(CFG_EFFORT_MAX, 16'(cap));
        write_reg(CFG_STEP_CODE, 16'(sc));
        write_reg(CFG_SETUP_CODE, 16'(uc));
        cfg_bus.valid <= 1'b0;
        step_cmd = sc;
        setup_cmd = uc;
        @(posedge clk);
    endtask

    initial begin
        int          r;
        int          n_items;
        logic [15:0] rate;
        logic [15:0] floor_us;
        logic [6:0]  cap;
        logic [1:0]  sc;
        logic [1:0]  uc;
        logic [7:0]  b0;
        logic [7:0]  b1;
        hold_asked = 0;
        hold_served = 0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        step_cmd = STEP_CODE_RST;
        setup_cmd = SETUP_CODE_RST;
        rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.kind = KIND_TICK;
        item_bus.byte0 = 8'd0;
        item_bus.byte1 = 8'd0;
        item_bus.byte2 = 8'd0;
        item_bus.byte3 = 8'd0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_RATE_CONSTANT;
        cfg_bus.data = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(16'd8, 16'd1, 7'd127, STEP_CODE_RST, SETUP_CODE_RST);
        send_tick();
        send_frame(8'h00, 8'h00, 8'h00, 1'b1);
        send_frame(8'hff, 8'hff, 8'hff, 1'b1);
        send_frame({step_cmd, 1'b1, 5'h00}, 8'd3, 8'd255, 1'b0);
        send_frame({setup_cmd, 6'h3f}, 8'd255, 8'd0, 1'b1);
        send_frame({step_cmd, 1'b0, 5'h00}, 8'd0, 8'd255, 1'b1);
        send_tick();
        send_tick();
        send_frame({step_cmd, 1'b1, 5'h00}, 8'd3, 8'd255, 1'b1);
        repeat (4) send_tick();
        send_frame({step_cmd, 1'b0, 5'h1f}, 8'hff, 8'd4, 1'b1);
        repeat (4) send_tick();
        send_frame({setup_cmd, 6'h00}, 8'd0, 8'd7, 1'b1);
        repeat (2) send_tick();
        send_frame({step_cmd, 1'b1, 5'h00}, 8'd1, 8'd0, 1'b1);
        send_frame({setup_cmd, 6'h15}, 8'd64, 8'd0, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            n_items = PHASE_ITEMS;
            src_idle = 1'b1;
            sink_idle = 1'b1;
            case (p)
                0: begin
                    rate = RATE_CONSTANT_RST; floor_us = MIN_INTERVAL_RST; cap = EFFORT_MAX_RST;
                    sc = STEP_CODE_RST; uc = SETUP_CODE_RST;
                end
                1: begin
                    rate = 16'($urandom_range(1, 64)); floor_us = 16'd1; cap = 7'd127;
                    sc = CMD_SPARE_LO; uc = CMD_SPARE_HI;
                    src_idle = 1'b0;
                    sink_idle = 1'b0;
                end
                2: begin
                    rate = 16'd1; floor_us = 16'd1; cap = 7'd0;
                    sc = SETUP_CODE_RST; uc = SETUP_CODE_RST;
                end
                3: begin
                    rate = 16'hffff; floor_us = 16'hffff; cap = 7'd127;
                    sc = CMD_SPARE_HI; uc = CMD_SPARE_LO;
                    n_items = 60;
                end
                4: begin
                    rate = 16'($urandom_range(1, 400)); floor_us = 16'($urandom_range(1, 4));
                    cap = 7'($urandom_range(0, 127));
                    sc = 2'($urandom); uc = 2'($urandom);
                end
                5: begin
                    rate = 16'd200; floor_us = 16'd2; cap = 7'd100;
                    sc = STEP_CODE_RST; uc = SETUP_CODE_RST;
                end
                6: begin
                    rate = 16'($urandom_range(1, 65535)); floor_us = 16'($urandom_range(1, 65535));
                    cap = 7'($urandom);
                    sc = 2'($urandom); uc = 2'($urandom);
                    n_items = 120;
                end
                default: begin
                    rate = 16'd32; floor_us = 16'd1; cap = 7'd127;
                    sc = STEP_CODE_RST; uc = CMD_SPARE_HI;
                end
            endcase
            load_settings(rate, floor_us, cap, sc, uc);
            if (p == 2)
                hold_asked++;

            for (int i = 0; i < n_items; i++) begin
                r = $urandom_range(99);
                if (r < 62) begin
                    send_tick();
                end
                else if (r < 76) begin
                    r = $urandom_range(99);
                    b0 = {step_cmd, 1'($urandom), 5'h00};
                    b1 = 8'($urandom_range(0, 12));
                    if (r >= 90) begin
                        b0[4:0] = 5'($urandom);
                        b1 = 8'($urandom);
                    end
                    else if (r >= 80) begin
                        b0[4:0] = 5'h1f;
                        b1 = 8'hff;
                    end
                    else if (r >= 50) begin
                        b1 = 8'($urandom);
                    end
                    send_frame(b0, b1, ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom), 1'b1);
                end
                else if (r < 86) begin
                    send_frame({setup_cmd, 6'($urandom)}, 8'($urandom), 8'($urandom), 1'b1);
                end
                else if (r < 91) begin
                    send_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                end
                else
                begin
                    send_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                end
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> stepper_microstep_command_controller_top.f
hdl/smc_pkg.sv
hdl/smc_if.sv
hdl/smc_div.sv
hdl/smc_datapath.sv
hdl/smc_ctrl.sv
hdl/stepper_microstep_command_controller_top.sv
dv/smc_checker.sv
dv/tb.sv
